FILE: hw/rtl/ffba_pkg.sv
// Shared types, constants and table geometry for the first-fit block allocator.
`default_nettype none
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 32;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int APB_AW       = 3;
  localparam int NEED_W       = 34;

  localparam logic [31:0] MAX_REQUEST_RST = 32'd100000000;
  localparam logic [31:0] HEAP_LIMIT_RST  = 32'd16777216;

  localparam logic REG_MAX_REQUEST = 1'b0;
  localparam logic REG_HEAP_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_CALLOC  = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_REALLOC = 2'd3
  } ffba_cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_BAD   = 2'd1,
    STS_NOMEM = 2'd2,
    STS_NOP   = 2'd3
  } ffba_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_HCHK,
    ST_SCAN,
    ST_APPEND,
    ST_FREEOLD,
    ST_DONE
  } ffba_state_e;

  typedef struct packed {
    ffba_cmd_e   cmd;
    logic [31:0] request_size;
    logic [31:0] element_count;
    logic        has_handle;
    logic [5:0]  handle;
  } ffba_item_t;

  typedef struct packed {
    ffba_status_e status;
    logic [5:0]   out_handle;
    logic [31:0]  address;
    logic [6:0]   free_block_count;
    logic [31:0]  free_byte_count;
    logic [6:0]   total_block_count;
    logic [31:0]  total_byte_count;
  } ffba_result_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free_mark;
  } ffba_entry_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    ffba_entry_t       wdata;
    logic [IDX_W-1:0]  raddr;
  } ffba_tbl_req_t;

endpackage
`default_nettype wire

FILE: hw/rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: sequencer, statistics and register port.
//
// Channel   | Direction | Handshake                       | Word
// ----------+-----------+---------------------------------+----------------------
// command   | in        | start high while busy low       | item_i (ffba_item_t)
// result    | out       | done_o strobe, one cycle        | result_o (ffba_result_t)
// registers | in/out    | APB write: psel,penable,pwrite  | pwdata / prdata
//
// The first-fit scan reads one table entry per cycle through the single read
// port of the table memory.
// Reset clears the counters, the heap top and the registers to their defaults;
// the table itself needs no clearing, as entries at or above the block count
// are never used. The receiver cannot stall: the result word is shown for one
// cycle and the block is ready again in the cycle after.
`default_nettype none
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire ffba_item_t        item_i,
  output logic                   done_o,
  output ffba_result_t           result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  ffba_state_e state_q, state_d;

  logic [31:0] max_req_q, heap_lim_q;

  ffba_cmd_e   cmd_q;
  logic [31:0] size_q, count_q;
  logic        has_q;
  logic [5:0]  h_q;
  logic [63:0] prod;

  logic [31:0]      req_q, req_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic             relo_q, relo_d;
  ffba_entry_t      old_q, old_d;

  ffba_status_e     status_q, status_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [31:0]      addr_q, addr_d;

  logic [CNT_W-1:0] tot_q, tot_d;
  logic [CNT_W-1:0] fblk_q, fblk_d;
  logic [31:0]      fbyte_q, fbyte_d;
  logic [31:0]      tbyte_q, tbyte_d;
  logic [31:0]      heap_top_q, heap_top_d;

  ffba_tbl_req_t tbl_req;
  ffba_entry_t   rd;

  logic              accept;
  logic [31:0]       req_eff;
  logic              bad_size;
  logic              h_ok;
  logic              hit;
  logic              more;
  logic [NEED_W-1:0] need;
  logic              room;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign pready = 1'b1;

  ffba_mul u_mul (
    .clk_i (clk_i),
    .en_i  (accept),
    .a_i   (item_i.request_size),
    .b_i   (item_i.element_count),
    .p_o   (prod)
  );

  ffba_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q  <= MAX_REQUEST_RST;
      heap_lim_q <= HEAP_LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_MAX_REQUEST: max_req_q  <= pwdata;
        REG_HEAP_LIMIT:  heap_lim_q <= pwdata;
        default:         max_req_q  <= max_req_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_REQUEST: prdata = max_req_q;
      REG_HEAP_LIMIT:  prdata = heap_lim_q;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= item_i.cmd;
      size_q  <= item_i.request_size;
      count_q <= item_i.element_count;
      has_q   <= item_i.has_handle;
      h_q     <= item_i.handle;
    end
  end

  assign req_eff  = (cmd_q == CMD_CALLOC) ? prod[31:0] : size_q;
  assign bad_size = (cmd_q == CMD_CALLOC) ?
                    (size_q == '0 || count_q == '0 || prod > 64'(max_req_q)) :
                    (size_q == '0 || size_q > max_req_q);
  assign h_ok     = 32'(h_q) < 32'(tot_q);
  assign hit      = chk_vld_q && rd.free_mark && (rd.size >= req_q);
  assign more     = scan_q < tot_q;
  assign need     = NEED_W'(heap_top_q) + NEED_W'(req_q) + NEED_W'(HEADER_BYTES);
  assign room     = (32'(tot_q) < 32'(MAX_BLOCKS)) && (need <= NEED_W'(heap_lim_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        unique case (cmd_q)
          CMD_FREE: begin
            state_d = (has_q && h_ok) ? ST_HCHK : ST_DONE;
          end
          CMD_REALLOC: begin
            priority if (bad_size) begin
              state_d = ST_DONE;
            end else if (!has_q) begin
              state_d = ST_SCAN;
            end else if (!h_ok) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_HCHK;
            end
          end
          default: begin
            state_d = bad_size ? ST_DONE : ST_SCAN;
          end
        endcase
      end
      ST_HCHK: begin
        if (cmd_q == CMD_REALLOC && rd.size < req_q) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        priority if (hit) begin
          state_d = relo_q ? ST_FREEOLD : ST_DONE;
        end else if (chk_vld_q || more) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        state_d = (room && relo_q) ? ST_FREEOLD : ST_DONE;
      end
      ST_FREEOLD: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_d      = req_q;
    scan_d     = scan_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    relo_d     = relo_q;
    old_d      = old_q;
    status_d   = status_q;
    idx_d      = idx_q;
    addr_d     = addr_q;
    tot_d      = tot_q;
    fblk_d     = fblk_q;
    fbyte_d    = fbyte_q;
    tbyte_d    = tbyte_q;
    heap_top_d = heap_top_q;
    tbl_req    = '{we: 1'b0, waddr: IDX_W'(h_q), wdata: rd, raddr: IDX_W'(h_q)};

    unique case (state_q)
      ST_PREP: begin
        req_d    = req_eff;
        scan_d   = '0;
        relo_d   = 1'b0;
        idx_d    = '0;
        addr_d   = '0;
        status_d = STS_OK;
        unique case (cmd_q)
          CMD_FREE: begin
            priority if (!has_q) begin
              status_d = STS_NOP;
            end else if (!h_ok) begin
              status_d = STS_BAD;
            end else begin
              status_d = STS_OK;
            end
          end
          CMD_REALLOC: begin
            if (bad_size || (has_q && !h_ok)) begin
              status_d = STS_BAD;
            end
          end
          default: begin
            if (bad_size) begin
              status_d = STS_BAD;
            end
          end
        endcase
      end
      ST_HCHK: begin
        if (cmd_q == CMD_FREE) begin
          if (rd.free_mark) begin
            status_d = STS_NOP;
          end else begin
            tbl_req.we              = 1'b1;
            tbl_req.wdata.free_mark = 1'b1;
            fblk_d  = fblk_q + CNT_W'(1);
            fbyte_d = fbyte_q + rd.size;
            idx_d   = IDX_W'(h_q);
            addr_d  = rd.start + 32'(HEADER_BYTES);
          end
        end else if (rd.size >= req_q) begin
          idx_d  = IDX_W'(h_q);
          addr_d = rd.start + 32'(HEADER_BYTES);
        end else begin
          old_d  = rd;
          relo_d = 1'b1;
        end
      end
      ST_SCAN: begin
        tbl_req.raddr = scan_q[IDX_W-1:0];
        if (hit) begin
          tbl_req.we              = 1'b1;
          tbl_req.waddr           = chk_idx_q;
          tbl_req.wdata.free_mark = 1'b0;
          fblk_d  = fblk_q - CNT_W'(1);
          fbyte_d = fbyte_q - rd.size;
          idx_d   = chk_idx_q;
          addr_d  = rd.start + 32'(HEADER_BYTES);
        end else if (more) begin
          chk_vld_d = 1'b1;
          chk_idx_d = scan_q[IDX_W-1:0];
          scan_d    = scan_q + CNT_W'(1);
        end
      end
      ST_APPEND: begin
        if (room) begin
          tbl_req.we    = 1'b1;
          tbl_req.waddr = tot_q[IDX_W-1:0];
          tbl_req.wdata = '{start: heap_top_q, size: req_q, free_mark: 1'b0};
          heap_top_d    = need[31:0];
          tot_d         = tot_q + CNT_W'(1);
          tbyte_d       = tbyte_q + req_q;
          idx_d         = tot_q[IDX_W-1:0];
          addr_d        = heap_top_q + 32'(HEADER_BYTES);
        end else begin
          status_d = STS_NOMEM;
        end
      end
      ST_FREEOLD: begin
        if (!old_q.free_mark) begin
          tbl_req.we    = 1'b1;
          tbl_req.wdata = '{start: old_q.start, size: old_q.size, free_mark: 1'b1};
          fblk_d        = fblk_q + CNT_W'(1);
          fbyte_d       = fbyte_q + old_q.size;
        end
      end
      default: begin
        chk_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      chk_vld_q  <= 1'b0;
      relo_q     <= 1'b0;
      tot_q      <= '0;
      fblk_q     <= '0;
      fbyte_q    <= '0;
      tbyte_q    <= '0;
      heap_top_q <= '0;
    end else begin
      state_q    <= state_d;
      chk_vld_q  <= chk_vld_d;
      relo_q     <= relo_d;
      tot_q      <= tot_d;
      fblk_q     <= fblk_d;
      fbyte_q    <= fbyte_d;
      tbyte_q    <= tbyte_d;
      heap_top_q <= heap_top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    scan_q    <= scan_d;
    chk_idx_q <= chk_idx_d;
    old_q     <= old_d;
    status_q  <= status_d;
    idx_q     <= idx_d;
    addr_q    <= addr_d;
  end

  assign done_o = (state_q == ST_DONE);

  always_comb begin
    result_o.status            = status_q;
    result_o.out_handle        = 6'(idx_q);
    result_o.address           = addr_q;
    result_o.free_block_count  = 7'(fblk_q);
    result_o.free_byte_count   = fbyte_q;
    result_o.total_block_count = 7'(tot_q);
    result_o.total_byte_count  = tbyte_q;
  end

  a_free_within_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fblk_q <= tot_q)
    else $error("More free blocks than blocks created.");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q <= CNT_W'(MAX_BLOCKS))
    else $error("Block count exceeds the table depth.");

  a_done_then_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("Block still busy after delivering a result.");

  a_check_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (state_q == ST_SCAN))
    else $error("Pending table compare outside the scan.");

endmodule
`default_nettype wire

FILE: hw/rtl/ffba_table.sv
// Block table memory holding start, size and free mark of every created block.
`default_nettype none
module ffba_table
  import ffba_pkg::*;
(
  input  wire logic          clk_i,
  input  wire ffba_tbl_req_t req_i,
  output ffba_entry_t        rdata_o
);

  ffba_entry_t mem_q [MAX_BLOCKS];
  ffba_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ffba_mul.sv
// Registered 32 by 32 multiplier that forms the calloc byte count.
`default_nettype none
module ffba_mul
  import ffba_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [63:0]      p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 64'(a_i) * 64'(b_i);
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire
